### hw/rtl/utf8_lenient_decoder_macros.svh
// Assertion helpers for the decoder
`ifndef UTF8_LENIENT_DECODER_MACROS_SVH
`define UTF8_LENIENT_DECODER_MACROS_SVH

// same-cycle implication
`define U8LD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define U8LD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### hw/rtl/u8ld_pkg.sv
package u8ld_pkg;

  localparam int unsigned QDepth = 2;
  localparam int unsigned MaxRes = 4;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       string_end;
  } in_t;

  typedef struct packed {
    logic [20:0] codepoint;
    logic        fell_back;
    logic        text_done;
    logic        run_last;
  } out_t;

  typedef struct packed {
    logic [20:0] cp;
    logic        fb;
  } res_t;

  typedef struct packed {
    logic [1:0]              last_idx;
    logic                    str_end;
    res_t [MaxRes-1:0]       res;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef enum logic [1:0] {
    LEAD_ASCII = 2'd0,
    LEAD_MULTI = 2'd1,
    LEAD_BAD   = 2'd2
  } lead_class_t;

endpackage

### hw/rtl/u8ld_front.sv
module u8ld_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  u8ld_pkg::in_t    in_item,
  input  logic             q_full,
  output logic             push,
  output u8ld_pkg::cmd_t   cmd
);
  import u8ld_pkg::*;

  logic [7:0]  lead_held, lead_held_next;
  logic [1:0]  bytes_needed, bytes_needed_next;
  logic [1:0]  bytes_seen, bytes_seen_next;
  logic [20:0] value_acc, value_acc_next;
  logic [7:0]  cont_buffer [2];

  logic        accept;
  logic        buf_we;
  logic [2:0]  n;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign push     = accept && (n != 3'd0);

  always_comb begin
    logic [7:0]  b;
    logic        last;
    logic        is_cont;
    logic        do_lead;
    logic [1:0]  base;
    logic [1:0]  need;
    logic [20:0] init;
    logic [20:0] shifted;
    lead_class_t cls;

    b       = in_item.in_byte;
    last    = in_item.string_end;
    is_cont = (b[7:6] == 2'b10);
    shifted = {value_acc[14:0], b[5:0]};
    do_lead = 1'b0;
    base    = 2'd0;
    need    = 2'd0;
    init    = '0;
    cls     = LEAD_ASCII;
    n       = 3'd0;
    buf_we  = 1'b0;
    cmd     = '0;
    cmd.str_end = last;

    lead_held_next    = lead_held;
    bytes_needed_next = bytes_needed;
    bytes_seen_next   = bytes_seen;
    value_acc_next    = value_acc;

    if (bytes_needed == 2'd0) begin
      do_lead = 1'b1;
    end else if (is_cont && ({1'b0, bytes_seen} + 3'd1 == {1'b0, bytes_needed})) begin
      cmd.res[0] = '{cp: shifted, fb: 1'b0};
      n = 3'd1;
      lead_held_next    = '0;
      bytes_needed_next = '0;
      bytes_seen_next   = '0;
      value_acc_next    = '0;
    end else if (is_cont && !last && (bytes_seen < 2'd2)) begin
      buf_we          = 1'b1;
      value_acc_next  = shifted;
      bytes_seen_next = bytes_seen + 2'd1;
    end else begin
      cmd.res[0] = '{cp: {13'd0, lead_held}, fb: 1'b1};
      cmd.res[1] = '{cp: {13'd0, cont_buffer[0]}, fb: 1'b1};
      cmd.res[2] = '{cp: {13'd0, cont_buffer[1]}, fb: 1'b1};
      base = bytes_seen + 2'd1;
      n    = {1'b0, base};
      do_lead = 1'b1;
      lead_held_next    = '0;
      bytes_needed_next = '0;
      bytes_seen_next   = '0;
      value_acc_next    = '0;
    end

    if (do_lead) begin
      case (b) inside
        [8'h00:8'h7F]: begin cls = LEAD_ASCII; end
        [8'hC0:8'hDF]: begin cls = LEAD_MULTI; need = 2'd1; init = {16'd0, b[4:0]}; end
        [8'hE0:8'hEF]: begin cls = LEAD_MULTI; need = 2'd2; init = {17'd0, b[3:0]}; end
        [8'hF0:8'hF7]: begin cls = LEAD_MULTI; need = 2'd3; init = {18'd0, b[2:0]}; end
        default:       begin cls = LEAD_BAD; end
      endcase
      if (cls == LEAD_MULTI && !last) begin
        lead_held_next    = b;
        bytes_needed_next = need;
        bytes_seen_next   = '0;
        value_acc_next    = init;
      end else begin
        cmd.res[base] = '{cp: {13'd0, b}, fb: (cls != LEAD_ASCII)};
        n = {1'b0, base} + 3'd1;
      end
    end

    cmd.last_idx = 2'(n - 3'd1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lead_held    <= '0;
      bytes_needed <= '0;
      bytes_seen   <= '0;
      value_acc    <= '0;
    end else if (accept) begin
      lead_held    <= lead_held_next;
      bytes_needed <= bytes_needed_next;
      bytes_seen   <= bytes_seen_next;
      value_acc    <= value_acc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && buf_we) begin
      cont_buffer[bytes_seen[0]] <= in_item.in_byte;
    end
  end

endmodule

### hw/rtl/u8ld_queue.sv
module u8ld_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  u8ld_pkg::cmd_t      push_cmd,
  input  logic                pop,
  output u8ld_pkg::cmd_t      head,
  output u8ld_pkg::q_status_t status
);
  import u8ld_pkg::*;

  localparam int unsigned PtrW = $clog2(QDepth);
  localparam int unsigned CntW = $clog2(QDepth + 1);

  cmd_t            entries [QDepth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;

  assign status.full  = (count == CntW'(QDepth));
  assign status.empty = (count == '0);
  assign head         = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(QDepth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(QDepth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   begin count <= count + 1'b1; end
        2'b01:   begin count <= count - 1'b1; end
        default: begin count <= count; end
      endcase
    end
  end

endmodule

### hw/rtl/u8ld_back.sv
module u8ld_back (
  input  logic                clk,
  input  logic                rst,
  input  u8ld_pkg::cmd_t      head,
  input  logic                head_valid,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output u8ld_pkg::out_t      out_item
);
  import u8ld_pkg::*;

  logic [1:0] idx;
  logic       load;
  logic       is_last;
  res_t       cur;

  assign load    = head_valid && (!out_valid || !out_stall);
  assign is_last = (idx == head.last_idx);
  assign cur     = head.res[idx];
  assign pop     = load && is_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        idx       <= is_last ? 2'd0 : idx + 2'd1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_item.codepoint <= cur.cp;
      out_item.fell_back <= cur.fb;
      out_item.run_last  <= is_last;
      out_item.text_done <= is_last && head.str_end;
    end
  end

endmodule

### hw/rtl/utf8_lenient_decoder.sv
// Lenient UTF-8 decoder: one byte per beat in, one codepoint per beat out, with
// broken sequences passed through as Latin-1 bytes flagged by fell_back. The
// input side takes a byte every cycle while its two-entry command queue has
// room; a byte that completes or rejects a sequence produces one to four
// results, which the output register hands out one per cycle while out_stall
// is low, and the input stalls only once both queue entries are waiting.
// Bytes that are buffered inside an open sequence produce nothing. Each
// result is registered first in a queue entry, then in the output register.
`include "utf8_lenient_decoder_macros.svh"

module utf8_lenient_decoder (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  u8ld_pkg::in_t   in_item,
  output logic            out_valid,
  input  logic            out_stall,
  output u8ld_pkg::out_t  out_item
);
  import u8ld_pkg::*;

  logic      push;
  logic      pop;
  cmd_t      push_cmd;
  cmd_t      head;
  q_status_t q_status;

  u8ld_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .q_full   (q_status.full),
    .push     (push),
    .cmd      (push_cmd)
  );

  u8ld_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .status   (q_status)
  );

  u8ld_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (!q_status.empty),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_item   (out_item)
  );

  `U8LD_ASSERT_NOW(a_pop_nonempty, pop, !q_status.empty)
  `U8LD_ASSERT_NOW(a_push_room, push, !q_status.full)
  `U8LD_ASSERT_NOW(a_done_is_last, out_valid && out_item.text_done, out_item.run_last)
  `U8LD_ASSERT_NOW(a_decoded_is_last, out_valid && !out_item.fell_back, out_item.run_last)

endmodule

### sim/utf8_lenient_decoder_tb.sv
module utf8_lenient_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import u8ld_pkg::*;

  localparam int unsigned IdleLimit  = 2000;
  localparam int unsigned HoldCycles = 150;
  localparam int unsigned ShownMax   = 10;
  localparam int unsigned SettleWait = 20;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic in_valid  = 1'b0;
  logic in_stall;
  in_t  in_item   = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_item;

  utf8_lenient_decoder dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // decoder state as predicted
  logic [7:0]  seq_lead = '0;
  logic [1:0]  seq_need = '0;
  logic [1:0]  seq_seen = '0;
  logic [20:0] seq_acc  = '0;
  logic [7:0]  seq_cont [2];
  res_t        burst [$];
  out_t        cp_due [$];
  out_t        due_cp;

  logic [7:0]  text_q [$];
  int unsigned beats_sent  = 0;
  int unsigned fault_count = 0;
  int unsigned idle_cycles = 0;
  int unsigned hold_len    = 0;
  bit          tx_gaps     = 1'b1;
  bit          rx_gaps     = 1'b1;

  function automatic void note_fault(input string what);
    fault_count++;
    if (fault_count <= ShownMax) $display("mismatch: %s", what);
  endfunction

  function automatic void emit(input logic [20:0] cp, input logic fb);
    burst.insert(burst.size(), {cp, fb});
  endfunction

  function automatic void close_seq();
    seq_lead = '0;
    seq_need = '0;
    seq_seen = '0;
    seq_acc  = '0;
  endfunction

  function automatic lead_class_t lead_kind(input logic [7:0] b);
    if (!b[7]) return LEAD_ASCII;
    if (b[7:5] == 3'b110 || b[7:4] == 4'b1110 || b[7:3] == 5'b11110) return LEAD_MULTI;
    return LEAD_BAD;
  endfunction

  function automatic void take_lead(input logic [7:0] b, input logic last);
    case (lead_kind(b))
      LEAD_ASCII: emit(21'(b), 1'b0);
      LEAD_MULTI: begin
        if (last) begin
          emit(21'(b), 1'b1);
        end else begin
          seq_lead = b;
          seq_seen = 2'd0;
          if (!b[5]) begin
            seq_need = 2'd1;
            seq_acc  = 21'(b[4:0]);
          end else if (!b[4]) begin
            seq_need = 2'd2;
            seq_acc  = 21'(b[3:0]);
          end else begin
            seq_need = 2'd3;
            seq_acc  = 21'(b[2:0]);
          end
        end
      end
      default: emit(21'(b), 1'b1);
    endcase
  endfunction

  function automatic void decode_byte(input in_t beat);
    logic [7:0] b;
    logic       last;
    logic       cont;
    b    = beat.in_byte;
    last = beat.string_end;
    cont = (b[7:6] == 2'b10);
    burst.delete();
    if (seq_need == 2'd0) begin
      take_lead(b, last);
    end else if (cont && ({1'b0, seq_seen} + 3'd1 == {1'b0, seq_need})) begin
      emit({seq_acc[14:0], b[5:0]}, 1'b0);
      close_seq();
    end else if (cont && !last && seq_seen < 2'd2) begin
      seq_cont[seq_seen[0]] = b;
      seq_acc  = {seq_acc[14:0], b[5:0]};
      seq_seen = seq_seen + 2'd1;
    end else begin
      emit(21'(seq_lead), 1'b1);
      for (int k = 0; k < int'(seq_seen); k++) emit(21'(seq_cont[k]), 1'b1);
      close_seq();
      take_lead(b, last);
    end
    foreach (burst[k])
      cp_due.insert(cp_due.size(), {burst[k].cp, burst[k].fb,
                    last && (k == burst.size() - 1), k == burst.size() - 1});
  endfunction

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) decode_byte(in_item);
      if (out_valid && !out_stall) begin
        if (cp_due.size() == 0) begin
          note_fault($sformatf("unexpected cp=%06h fb=%0b done=%0b last=%0b",
                               out_item.codepoint, out_item.fell_back,
                               out_item.text_done, out_item.run_last));
        end else begin
          due_cp = cp_due.pop_front();
          if (due_cp.codepoint !== out_item.codepoint || due_cp.fell_back !== out_item.fell_back ||
              due_cp.text_done !== out_item.text_done || due_cp.run_last !== out_item.run_last)
            note_fault($sformatf(
              "expected cp=%06h fb=%0b done=%0b last=%0b, got cp=%06h fb=%0b done=%0b last=%0b",
              due_cp.codepoint, due_cp.fell_back, due_cp.text_done, due_cp.run_last,
              out_item.codepoint, out_item.fell_back, out_item.text_done, out_item.run_last));
        end
      end
    end
  end

  initial begin
    int unsigned gap;
    forever begin
      if (hold_len != 0) begin
        gap      = hold_len;
        hold_len = 0;
      end else begin
        gap = rx_gaps ? $urandom_range(0, 8) : 0;
      end
      if (gap != 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!(out_valid && !rst)) @(posedge clk);
    end
  end

  initial begin
    while (idle_cycles < IdleLimit) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("utf8_lenient_decoder regression: fail");
    $finish;
  end

  task automatic send_beat(input logic [7:0] b, input logic last);
    int unsigned gap;
    gap = tx_gaps ? $urandom_range(0, 8) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_item  <= {b, last};
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    beats_sent++;
  endtask

  task automatic idle_input();
    in_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    @(posedge clk);
    while (cp_due.size() != 0) @(posedge clk);
  endtask

  function automatic void add_char(input int unsigned extra, input int unsigned drop);
    logic [7:0] lead;
    case (extra)
      0:       lead = 8'($urandom_range(0, 8'h7f));
      1:       lead = 8'hc0 | 8'($urandom_range(0, 31));
      2:       lead = 8'he0 | 8'($urandom_range(0, 15));
      default: lead = 8'hf0 | 8'($urandom_range(0, 7));
    endcase
    text_q.insert(text_q.size(), lead);
    for (int unsigned k = drop; k < extra; k++)
      text_q.insert(text_q.size(), 8'h80 | 8'($urandom_range(0, 63)));
  endfunction

  task automatic send_text(input int unsigned chars, input int unsigned noise_pct);
    int unsigned extra;
    text_q.delete();
    repeat (chars) begin
      if ($urandom_range(0, 99) < noise_pct) begin
        case ($urandom_range(0, 3))
          0: text_q.insert(text_q.size(), 8'($urandom_range(0, 255)));
          1: text_q.insert(text_q.size(), 8'($urandom_range(8'h80, 8'hbf)));
          2: text_q.insert(text_q.size(), 8'($urandom_range(8'hf8, 8'hff)));
          default: begin
            extra = $urandom_range(1, 3);
            add_char(extra, $urandom_range(1, extra));
          end
        endcase
      end else begin
        add_char($urandom_range(0, 3), 0);
      end
    end
    foreach (text_q[k]) send_beat(text_q[k], k == text_q.size() - 1);
  endtask

  task automatic test_directed();
    logic [8:0] beats [25];
    beats = '{{8'h00, 1'b0}, {8'h7f, 1'b1}, {8'hbf, 1'b0}, {8'hf8, 1'b0}, {8'hff, 1'b1},
              {8'hc3, 1'b0}, {8'ha9, 1'b1},
              {8'he2, 1'b0}, {8'h82, 1'b0}, {8'hac, 1'b1},
              {8'hf7, 1'b0}, {8'hbf, 1'b0}, {8'hbf, 1'b0}, {8'hbf, 1'b1},
              {8'hc3, 1'b1},
              {8'he2, 1'b0}, {8'h41, 1'b1},
              {8'hf0, 1'b0}, {8'h9f, 1'b0}, {8'h98, 1'b1},
              {8'hf0, 1'b0}, {8'h90, 1'b0}, {8'h80, 1'b0}, {8'hc2, 1'b0}, {8'ha2, 1'b1}};
    foreach (beats[k]) send_beat(beats[k][8:1], beats[k][0]);
  endtask

  task automatic test_random_text();
    while (beats_sent < 340) begin
      tx_gaps = ($urandom_range(0, 3) != 0);
      rx_gaps = ($urandom_range(0, 3) != 0);
      send_text($urandom_range(1, 12), 25);
    end
    tx_gaps = 1'b1;
    rx_gaps = 1'b1;
  endtask

  task automatic test_output_hold();
    // hold the output off while fallback bursts keep arriving
    tx_gaps  = 1'b0;
    hold_len = HoldCycles;
    repeat (4) send_text(8, 90);
    tx_gaps = 1'b1;
  endtask

  task automatic test_drain_pause();
    repeat (3) begin
      send_text(6, 20);
      idle_input();
      wait_drained();
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_random_text();
    test_output_hold();
    test_drain_pause();
    idle_input();
    wait_drained();
    repeat (SettleWait) @(posedge clk);
    if (fault_count == 0) begin
      $display("utf8_lenient_decoder regression: pass");
    end else begin
      $display("utf8_lenient_decoder regression: fail");
    end
    $finish;
  end

endmodule
